// ===== src/sumd_frame_decoder_top_defines.svh =====
// Assertion macros for the SUMD frame decoder
`ifndef SUMD_FRAME_DECODER_TOP_DEFINES_SVH
`define SUMD_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define SUMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SUMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sumd_pkg.sv =====
package sumd_pkg;

  localparam int CHANNELS    = 12;
  localparam int FRAME_BYTES = 3 + 2 * CHANNELS + 2;
  localparam int CRC_FIRST   = 3 + 2 * CHANNELS;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLY     = 2'd3;

  localparam logic [1:0] FS_OK        = 2'd0;
  localparam logic [1:0] FS_BAD_STAT  = 2'd1;
  localparam logic [1:0] FS_BAD_COUNT = 2'd2;
  localparam logic [1:0] FS_BAD_CRC   = 2'd3;

  localparam logic [7:0]  HEADER_RST   = 8'd168;
  localparam logic [7:0]  NORMAL_RST   = 8'd1;
  localparam logic [7:0]  FAILSAFE_RST = 8'd129;
  localparam logic [15:0] POLY_RST     = 16'd4129;

  // MSB-first CRC-16, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/sumd_ram.sv =====
module sumd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sumd_frame_decoder_top.sv =====
// Channel   Direction  Handshake              Payload
// rx        in         in_valid / in_stall    rx_byte
// result    out        out_valid / out_stall  channel_index, channel_value, failsafe,
//                                             frame_status, last
// cfg       in         cfg_write              cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; only the last byte of a frame starts an emission.
// A good or CRC-failed frame reads the channel RAM one word per result, through a read
// state then a load state, waiting to read while a result is held; no byte is taken meanwhile.
// Error frames give one result straight from the last byte.
// rst is synchronous; it restores defaults, returns to hunting and stalls the input.
// A stalled result holds the output register; bytes are still taken unless the
// held byte is the last one of a frame.
module sumd_frame_decoder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [3:0]                          channel_index,
  output logic [12:0]                         channel_value,
  output logic                                failsafe,
  output logic [1:0]                          frame_status,
  output logic                                last,
  input  logic                                cfg_write,
  input  logic [sumd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sumd_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "sumd_frame_decoder_top_defines.svh"

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_RD   = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state;

  logic [7:0]  header_byte;
  logic [7:0]  status_normal;
  logic [7:0]  status_failsafe;
  logic [15:0] crc_polynomial;

  logic [sumd_pkg::POS_W-1:0] pos;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  status_store;
  logic [7:0]  count_store;
  logic [7:0]  crc_high;
  logic [7:0]  hi_byte;
  logic [sumd_pkg::IDX_W-1:0] idx;
  logic        fs_hold;
  logic [1:0]  st_hold;

  logic        in_acc;
  logic        at_last;
  logic        out_free;
  logic        in_chan;
  logic [sumd_pkg::POS_W-1:0] off;
  logic        ram_wr;
  logic        ram_rd;
  logic [15:0] ram_rdata;
  logic        stat_bad;
  logic        fs_dec;
  logic        count_bad;
  logic        idx_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte     <= sumd_pkg::HEADER_RST;
      status_normal   <= sumd_pkg::NORMAL_RST;
      status_failsafe <= sumd_pkg::FAILSAFE_RST;
      crc_polynomial  <= sumd_pkg::POLY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        sumd_pkg::REG_HEADER:   header_byte     <= cfg_data[7:0];
        sumd_pkg::REG_NORMAL:   status_normal   <= cfg_data[7:0];
        sumd_pkg::REG_FAILSAFE: status_failsafe <= cfg_data[7:0];
        sumd_pkg::REG_POLY:     crc_polynomial  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign at_last  = (pos == sumd_pkg::POS_W'(sumd_pkg::FRAME_BYTES - 1));
  assign in_stall = rst || (state != S_RUN) || (at_last && out_valid);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign crc_next = sumd_pkg::crc_byte(crc, rx_byte, crc_polynomial);
  assign off      = pos - sumd_pkg::POS_W'(3);
  assign in_chan  = (pos >= sumd_pkg::POS_W'(3)) &&
                    (pos < sumd_pkg::POS_W'(sumd_pkg::CRC_FIRST));
  assign ram_wr   = in_acc && in_chan && off[0];
  assign ram_rd   = (state == S_RD) && out_free;
  assign idx_last = (idx == sumd_pkg::IDX_W'(sumd_pkg::CHANNELS - 1));

  assign stat_bad  = (status_store != status_normal) && (status_store != status_failsafe);
  assign fs_dec    = (status_store == status_failsafe);
  assign count_bad = (count_store != 8'(sumd_pkg::CHANNELS));

  // writes happen only while collecting, reads only while emitting: no overlap
  sumd_ram #(
    .WIDTH (16),
    .DEPTH (sumd_pkg::CHANNELS)
  ) u_chan_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (sumd_pkg::IDX_W'(off >> 1)),
    .wr_data ({hi_byte, rx_byte}),
    .rd_en   (ram_rd),
    .rd_addr (idx),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (pos == sumd_pkg::POS_W'(1)) begin
        status_store <= rx_byte;
      end
      if (pos == sumd_pkg::POS_W'(2)) begin
        count_store <= rx_byte;
      end
      if (in_chan && !off[0]) begin
        hi_byte <= rx_byte;
      end
      if (pos == sumd_pkg::POS_W'(sumd_pkg::CRC_FIRST)) begin
        crc_high <= rx_byte;
      end
      if (at_last) begin
        fs_hold <= fs_dec;
        st_hold <= ({crc_high, rx_byte} != crc) ? sumd_pkg::FS_BAD_CRC : sumd_pkg::FS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      pos       <= '0;
      crc       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (in_acc) begin
            if (pos == '0) begin
              if (rx_byte == header_byte) begin
                crc <= crc_next;
                pos <= sumd_pkg::POS_W'(1);
              end
            end else if (pos < sumd_pkg::POS_W'(sumd_pkg::CRC_FIRST)) begin
              crc <= crc_next;
              pos <= pos + sumd_pkg::POS_W'(1);
            end else if (!at_last) begin
              pos <= pos + sumd_pkg::POS_W'(1);
            end else begin
              pos <= '0;
              crc <= '0;
              if (stat_bad || count_bad) begin
                out_valid <= 1'b1;
              end else begin
                idx   <= '0;
                state <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          if (ram_rd) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          if (idx_last) begin
            state <= S_RUN;
          end else begin
            idx   <= idx + sumd_pkg::IDX_W'(1);
            state <= S_RD;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      channel_index <= 4'(idx);
      channel_value <= ram_rdata[15:3];
      failsafe      <= fs_hold;
      frame_status  <= st_hold;
      last          <= idx_last;
    end else if (in_acc && at_last && (stat_bad || count_bad)) begin
      channel_index <= '0;
      channel_value <= '0;
      failsafe      <= stat_bad ? 1'b0 : fs_dec;
      frame_status  <= stat_bad ? sumd_pkg::FS_BAD_STAT : sumd_pkg::FS_BAD_COUNT;
      last          <= 1'b1;
    end
  end

  `SUMD_ASSERT_NOW(a_err_single,
    out_valid && (frame_status == sumd_pkg::FS_BAD_STAT ||
                  frame_status == sumd_pkg::FS_BAD_COUNT),
    last && (channel_index == 4'd0) && (channel_value == 13'd0),
    "error word must be a lone last word")
  `SUMD_ASSERT_NEXT(a_last_emits, in_acc && at_last, out_valid || (state == S_RD),
    "last byte must start an emission")
  `SUMD_ASSERT_NEXT(a_word_follows, out_valid && !out_stall && !last,
    state == S_RD || state == S_LOAD, "channel words must continue to the last one")

endmodule
